// ----- rtl/l2tp_pkg.sv -----
// ----------------------------------------------------------------------------
// l2tp_pkg
// Shared types and constants of the L2TP tunnel packet classifier.
// ----------------------------------------------------------------------------
package l2tp_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 65536;
  localparam int QUEUE_DEPTH_DEF     = 4;
  localparam int OUT_DEPTH           = 2;
  localparam int CFG_INDEX_W         = 3;
  localparam int CFG_DATA_W          = 48;

  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ENABLE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WANT_SRC_IP   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WANT_DST_IP   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WANT_SRC_MAC  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WANT_DST_MAC  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_WANT_SRC_PORT = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_WANT_DST_PORT = 3'd6;

  localparam logic [2:0] CLS_CONTROL   = 3'd0;
  localparam logic [2:0] CLS_IP_UDP    = 3'd1;
  localparam logic [2:0] CLS_IP_TCP    = 3'd2;
  localparam logic [2:0] CLS_IP_ICMP   = 3'd3;
  localparam logic [2:0] CLS_IP_OTHER  = 3'd4;
  localparam logic [2:0] CLS_LCP       = 3'd5;
  localparam logic [2:0] CLS_CHAP      = 3'd6;
  localparam logic [2:0] CLS_PPP_OTHER = 3'd7;

  localparam logic [7:0]  ETH_IPV4_HI  = 8'h08;
  localparam logic [7:0]  ETH_IPV4_LO  = 8'h00;
  localparam logic [7:0]  IP_PROTO_UDP = 8'h11;
  localparam logic [7:0]  IP_PROTO_TCP = 8'h06;
  localparam logic [7:0]  IP_PROTO_ICMP = 8'h01;
  localparam logic [7:0]  PPP_ALL_STATIONS = 8'hFF;
  localparam logic [7:0]  PPP_CTRL     = 8'h03;
  localparam logic [15:0] PPP_IP       = 16'h0021;
  localparam logic [15:0] PPP_LCP      = 16'hC021;
  localparam logic [15:0] PPP_CHAP     = 16'hC223;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } frame_in_t;

  typedef struct packed {
    logic        report;
    logic [2:0]  frame_class;
    logic [15:0] tunnel_id;
    logic [15:0] sess_id;
    logic [15:0] outer_src_port;
    logic [15:0] outer_dst_port;
    logic [15:0] inner_src_port;
    logic [15:0] inner_dst_port;
    logic [31:0] report_number;
  } result_t;

  typedef struct packed {
    logic        ok;
    logic        ctl;
    logic [2:0]  cls;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [31:0] outer_src_ip;
    logic [31:0] outer_dst_ip;
    logic [31:0] inner_src_ip;
    logic [31:0] inner_dst_ip;
    logic [15:0] outer_sp;
    logic [15:0] outer_dp;
    logic [15:0] tunnel;
    logic [15:0] session;
    logic [15:0] inner_sp;
    logic [15:0] inner_dp;
  } frame_sum_t;

endpackage

// ----- rtl/l2tp_tunnel_packet_classifier.sv -----
// ----------------------------------------------------------------------------
// l2tp_tunnel_packet_classifier
// L2TP-over-UDP/IPv4 frame classifier and filter, one frame byte per beat.
// ----------------------------------------------------------------------------
// Throughput: one frame byte is accepted every cycle while the summary queue is not full.
// The frame summary is written into the summary queue with the last accepted byte;
// the filter moves it into the result queue as a result beat, which waits there for pop.
// Input stalls only when the summary queue between parser and filter is full.
// Synchronous reset empties both queues and clears all registers and counts.
module l2tp_tunnel_packet_classifier
  import l2tp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  frame_in_t              frame,
  output logic                   empty,
  input  logic                   pop,
  output result_t                result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);
  logic       accept;
  logic       sum_push, sum_empty, sum_take, res_full, res_push;
  frame_sum_t sum_in, sum_out;
  result_t    res;

  assign accept = push && !full;

  l2tp_parse #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_parse (
    .clk(clk), .rst(rst), .accept(accept), .frame(frame),
    .sum_push(sum_push), .sum(sum_in)
  );

  l2tp_fifo #(.WIDTH($bits(frame_sum_t)), .DEPTH(QUEUE_DEPTH)) u_sum_q (
    .clk(clk), .rst(rst), .wr(sum_push), .wdata(sum_in), .rd(sum_take),
    .rdata(sum_out), .full(full), .empty(sum_empty)
  );

  l2tp_filter u_filter (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .sum_valid(!sum_empty), .sum(sum_out),
    .sum_take(sum_take), .res_full(res_full), .res_push(res_push), .res(res)
  );

  l2tp_fifo #(.WIDTH($bits(result_t)), .DEPTH(OUT_DEPTH)) u_res_q (
    .clk(clk), .rst(rst), .wr(res_push), .wdata(res), .rd(pop),
    .rdata(result), .full(res_full), .empty(empty)
  );
endmodule

// ----- rtl/l2tp_fifo.sv -----
// ----------------------------------------------------------------------------
// l2tp_fifo
// Small first-in first-out queue of fixed-width entries.
// ----------------------------------------------------------------------------
module l2tp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      fill;
  logic             do_wr;
  logic             do_rd;

  assign full  = (fill == (AW+1)'(DEPTH));
  assign empty = (fill == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end
endmodule

// ----- rtl/l2tp_parse.sv -----
// ----------------------------------------------------------------------------
// l2tp_parse
// Byte-wise header parser; emits one frame summary on the last byte.
// ----------------------------------------------------------------------------
module l2tp_parse
  import l2tp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  frame_in_t  frame,
  output logic       sum_push,
  output frame_sum_t sum
);
  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CW = (PW > 10) ? PW : 10;

  logic [PW-1:0] pos;
  logic [5:0]    ohl, ohl_next, ihl, ihl_next;
  logic [7:0]    flags_hi, flags_hi_next;
  logic [CW-1:0] ppp_start, ppp_start_next;
  logic [47:0]   mac0, mac0_next, mac1, mac1_next;
  logic [31:0]   ip0, ip0_next, ip1, ip1_next, ip2, ip2_next, ip3, ip3_next;
  logic [15:0]   pt0, pt0_next, pt1, pt1_next, pt2, pt2_next, pt3, pt3_next;
  logic [15:0]   pt4, pt4_next, pt5, pt5_next, proto0, proto0_next;
  logic [7:0]    proto1, proto1_next;
  logic          rej, rej_next;

  logic [7:0]    b;
  logic [CW-1:0] p, u, h, t, q, inr;
  logic [CW:0]   cnt;
  logic          after, ctl, len_ok;
  logic [2:0]    cls;

  assign b = frame.frame_byte;
  assign p = CW'(pos);

  always_comb begin
    mac0_next      = mac0;
    mac1_next      = mac1;
    ip0_next       = ip0;
    ip1_next       = ip1;
    ip2_next       = ip2;
    ip3_next       = ip3;
    pt0_next       = pt0;
    pt1_next       = pt1;
    pt2_next       = pt2;
    pt3_next       = pt3;
    pt4_next       = pt4;
    pt5_next       = pt5;
    proto0_next    = proto0;
    proto1_next    = proto1;
    flags_hi_next  = flags_hi;
    ppp_start_next = ppp_start;
    ihl_next       = ihl;
    rej_next       = rej;

    if (p < CW'(6)) begin
      mac0_next = {mac0[39:0], b};
    end else if (p < CW'(12)) begin
      mac1_next = {mac1[39:0], b};
    end
    if ((p == CW'(12) && b != ETH_IPV4_HI) || (p == CW'(13) && b != ETH_IPV4_LO)) begin
      rej_next = 1'b1;
    end
    ohl_next = (p == CW'(14)) ? {b[3:0], 2'b00} : ohl;
    if (p == CW'(23) && b != IP_PROTO_UDP) begin
      rej_next = 1'b1;
    end
    if (p >= CW'(26) && p < CW'(30)) ip0_next = {ip0[23:0], b};
    if (p >= CW'(30) && p < CW'(34)) ip1_next = {ip1[23:0], b};

    u = CW'(14) + CW'(ohl_next);
    if (p == u || p == u + CW'(1)) pt0_next = {pt0[7:0], b};
    if (p == u + CW'(2) || p == u + CW'(3)) pt1_next = {pt1[7:0], b};

    h = u + CW'(8);
    if (p == h) begin
      flags_hi_next  = b;
      ppp_start_next = h + CW'(6) + (b[6] ? CW'(2) : '0) + (b[3] ? CW'(4) : '0)
                     + (b[1] ? CW'(2) : '0);
    end
    if (p == h + CW'(1)) begin
      if (flags_hi[7] && (!flags_hi[6] || !flags_hi[3] || flags_hi[1] || flags_hi[0])) begin
        rej_next = 1'b1;
      end
      if (flags_hi[5] || flags_hi[4] || flags_hi[2] || (b[7:4] != 4'd0)) begin
        rej_next = 1'b1;
      end
    end
    after = (p > h);

    t   = h + (flags_hi_next[6] ? CW'(4) : CW'(2));
    q   = ppp_start_next;
    ihl_next = (after && p == q + CW'(4)) ? {b[3:0], 2'b00} : ihl;
    inr = q + CW'(4) + CW'(ihl_next);
    if (after) begin
      if (p == t || p == t + CW'(1)) pt2_next = {pt2[7:0], b};
      if (p == t + CW'(2) || p == t + CW'(3)) pt3_next = {pt3[7:0], b};
      if (!flags_hi_next[7]) begin
        if ((p == q && b != PPP_ALL_STATIONS) || (p == q + CW'(1) && b != PPP_CTRL)) begin
          rej_next = 1'b1;
        end
      end
      if (p == q + CW'(2) || p == q + CW'(3)) proto0_next = {proto0[7:0], b};
      if (p == q + CW'(13)) proto1_next = b;
      if (p >= q + CW'(16) && p < q + CW'(20)) ip2_next = {ip2[23:0], b};
      if (p >= q + CW'(20) && p < q + CW'(24)) ip3_next = {ip3[23:0], b};
      if (p == inr || p == inr + CW'(1)) pt4_next = {pt4[7:0], b};
      if (p == inr + CW'(2) || p == inr + CW'(3)) pt5_next = {pt5[7:0], b};
    end
  end

  always_comb begin
    ctl    = flags_hi_next[7];
    cnt    = {1'b0, p} + (CW+1)'(1);
    len_ok = (cnt >= (CW+1)'(34)) && (cnt >= {1'b0, h} + (CW+1)'(2));
    cls    = CLS_CONTROL;
    if (!ctl) begin
      len_ok = len_ok && (cnt >= {1'b0, q} + (CW+1)'(4));
      if (proto0_next == PPP_IP) begin
        len_ok = len_ok && (cnt >= {1'b0, q} + (CW+1)'(24))
               && (cnt >= {1'b0, inr} + (CW+1)'(4));
        case (proto1_next)
          IP_PROTO_UDP:  cls = CLS_IP_UDP;
          IP_PROTO_TCP:  cls = CLS_IP_TCP;
          IP_PROTO_ICMP: cls = CLS_IP_ICMP;
          default:       cls = CLS_IP_OTHER;
        endcase
      end else if (proto0_next == PPP_LCP) begin
        cls = CLS_LCP;
      end else if (proto0_next == PPP_CHAP) begin
        cls = CLS_CHAP;
      end else begin
        cls = CLS_PPP_OTHER;
      end
    end
  end

  assign sum_push         = accept && frame.frame_end;
  assign sum.ok           = !rej_next && len_ok;
  assign sum.ctl          = ctl;
  assign sum.cls          = cls;
  assign sum.dst_mac      = mac0_next;
  assign sum.src_mac      = mac1_next;
  assign sum.outer_src_ip = ip0_next;
  assign sum.outer_dst_ip = ip1_next;
  assign sum.inner_src_ip = ip2_next;
  assign sum.inner_dst_ip = ip3_next;
  assign sum.outer_sp     = pt0_next;
  assign sum.outer_dp     = pt1_next;
  assign sum.tunnel       = pt2_next;
  assign sum.session      = pt3_next;
  assign sum.inner_sp     = pt4_next;
  assign sum.inner_dp     = pt5_next;

  always_ff @(posedge clk) begin
    if (rst || sum_push) begin
      pos <= '0; ohl <= '0; ihl <= '0; flags_hi <= '0;
      ppp_start <= '0; mac0 <= '0; mac1 <= '0;
      ip0 <= '0; ip1 <= '0; ip2 <= '0; ip3 <= '0;
      pt0 <= '0; pt1 <= '0; pt2 <= '0; pt3 <= '0; pt4 <= '0; pt5 <= '0;
      proto0 <= '0; proto1 <= '0; rej <= 1'b0;
    end else if (accept) begin
      if (pos < PW'(MAX_FRAME_BYTES)) begin
        pos <= pos + 1'b1;
      end
      ohl <= ohl_next; ihl <= ihl_next;
      flags_hi <= flags_hi_next;
      ppp_start <= ppp_start_next; mac0 <= mac0_next; mac1 <= mac1_next;
      ip0 <= ip0_next; ip1 <= ip1_next; ip2 <= ip2_next; ip3 <= ip3_next;
      pt0 <= pt0_next; pt1 <= pt1_next; pt2 <= pt2_next;
      pt3 <= pt3_next; pt4 <= pt4_next; pt5 <= pt5_next;
      proto0 <= proto0_next; proto1 <= proto1_next; rej <= rej_next;
    end
  end
endmodule

// ----- rtl/l2tp_filter.sv -----
// ----------------------------------------------------------------------------
// l2tp_filter
// Applies the per-class address and port filters, counts reported frames
// and builds the result beat.
// ----------------------------------------------------------------------------
module l2tp_filter
  import l2tp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   sum_valid,
  input  frame_sum_t             sum,
  output logic                   sum_take,
  input  logic                   res_full,
  output logic                   res_push,
  output result_t                res
);
  logic        filter_enable;
  logic [31:0] want_src_ip, want_dst_ip;
  logic [47:0] want_src_mac, want_dst_mac;
  logic [15:0] want_src_port, want_dst_port;
  logic [31:0] count, count_next;
  logic        pass, f1, f2, f3, f4, sip, dip, macok;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b0;
      want_src_ip   <= '0;
      want_dst_ip   <= '0;
      want_src_mac  <= '0;
      want_dst_mac  <= '0;
      want_src_port <= '0;
      want_dst_port <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        REG_WANT_SRC_IP:   want_src_ip   <= cfg_data[31:0];
        REG_WANT_DST_IP:   want_dst_ip   <= cfg_data[31:0];
        REG_WANT_SRC_MAC:  want_src_mac  <= cfg_data;
        REG_WANT_DST_MAC:  want_dst_mac  <= cfg_data;
        REG_WANT_SRC_PORT: want_src_port <= cfg_data[15:0];
        REG_WANT_DST_PORT: want_dst_port <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    f1    = (want_src_ip == '0) || (want_src_ip == sum.outer_src_ip);
    f2    = (want_dst_ip == '0) || (want_dst_ip == sum.outer_dst_ip);
    f3    = (want_src_port == '0) || (want_src_port == sum.outer_sp);
    f4    = (want_dst_port == '0) || (want_dst_port == sum.outer_dp);
    sip   = f1 || (want_src_ip == sum.inner_src_ip);
    dip   = f2 || (want_dst_ip == sum.inner_dst_ip);
    macok = ((want_src_mac == '0) || (want_src_mac == sum.src_mac))
         && ((want_dst_mac == '0) || (want_dst_mac == sum.dst_mac));
    pass  = sum.ok;
    if (sum.ok && filter_enable) begin
      case (sum.cls)
        CLS_CONTROL: pass = f1 && f2;
        CLS_IP_UDP:  pass = macok && sip && dip
                          && (f3 || want_src_port == sum.inner_sp)
                          && (f4 || want_dst_port == sum.inner_dp);
        CLS_IP_TCP:  pass = macok && sip && dip
                          && ((want_src_port == '0) || (want_src_port == sum.inner_sp))
                          && ((want_dst_port == '0) || (want_dst_port == sum.inner_dp));
        CLS_IP_ICMP: pass = macok && sip && dip && f3 && f4;
        CLS_LCP, CLS_CHAP: pass = macok && f1 && f2 && f3 && f4;
        default:     pass = 1'b0;
      endcase
    end
    count_next = pass ? count + 32'd1 : count;

    res                = '0;
    res.report_number  = count_next;
    if (pass) begin
      res.report         = 1'b1;
      res.frame_class    = sum.cls;
      res.outer_src_port = sum.outer_sp;
      res.outer_dst_port = sum.outer_dp;
      if (!sum.ctl) begin
        res.tunnel_id = sum.tunnel;
        res.sess_id   = sum.session;
      end
      if (sum.cls == CLS_IP_UDP || sum.cls == CLS_IP_TCP) begin
        res.inner_src_port = sum.inner_sp;
        res.inner_dst_port = sum.inner_dp;
      end
    end
  end

  assign sum_take = sum_valid && !res_full;
  assign res_push = sum_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (sum_take) begin
      count <= count_next;
    end
  end
endmodule

// ----- rtl/l2tp_checker.sv -----
// ----------------------------------------------------------------------------
// l2tp_props
// Port-level checks of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module l2tp_props
  import l2tp_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    empty,
  input logic    pop,
  input result_t result
);
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result beat changed");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.report) |-> (result.frame_class == '0 && result.tunnel_id == '0
      && result.sess_id == '0 && result.outer_src_port == '0
      && result.inner_src_port == '0 && result.inner_dst_port == '0))
    else $error("dropped frame carries field values");

  a_ctl_ids: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.report && result.frame_class == CLS_CONTROL)
      |-> (result.tunnel_id == '0 && result.sess_id == '0
           && result.inner_src_port == '0))
    else $error("control frame carries session fields");
endmodule

bind l2tp_tunnel_packet_classifier l2tp_props u_props (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .result(result)
);

// ----- bench/l2tp_checker.sv -----
// ----------------------------------------------------------------------------
// l2tp_checker
// Watches the frame, result and register ports of the L2TP classifier,
// predicts every frame verdict from the accepted bytes and compares it with
// the result that the block delivers.
// ----------------------------------------------------------------------------
module l2tp_checker
  import l2tp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic                   full,
  input  frame_in_t              frame,
  input  logic                   empty,
  input  logic                   pop,
  input  result_t                result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     errors,
  output int                     pending,
  output int                     reports_seen
);

  bit          flt_on;
  bit [31:0]   flt_sip, flt_dip;
  bit [47:0]   flt_smac, flt_dmac;
  bit [15:0]   flt_sport, flt_dport;

  int unsigned pos, ohl, pstart, ihl;
  bit [15:0]   l2tp_flags;
  bit [47:0]   macs[2];
  bit [31:0]   ips[4];
  bit [15:0]   words[6];
  bit [15:0]   protos[2];
  bit          rejected;
  bit [31:0]   verdict_count;

  result_t     verdict_q[$];

  function automatic void clear_frame_state();
    pos = 0; ohl = 0; pstart = 0; ihl = 0; l2tp_flags = '0; rejected = 0;
    macs = '{default: '0};
    ips = '{default: '0};
    words = '{default: '0};
    protos = '{default: '0};
  endfunction

  function automatic void parse_byte(int unsigned p, bit [7:0] b);
    int unsigned u, h, t, q, in_ports;
    bit [7:0] c;
    if (p < 6) macs[0] = {macs[0][39:0], b};
    else if (p < 12) macs[1] = {macs[1][39:0], b};
    if ((p == 12 && b != ETH_IPV4_HI) || (p == 13 && b != ETH_IPV4_LO)) rejected = 1;
    if (p == 14) ohl = b[3:0] * 4;
    if (p == 23 && b != IP_PROTO_UDP) rejected = 1;
    if (p >= 26 && p < 30) ips[0] = {ips[0][23:0], b};
    if (p >= 30 && p < 34) ips[1] = {ips[1][23:0], b};
    u = 14 + ohl;
    if (p == u || p == u + 1) words[0] = {words[0][7:0], b};
    if (p == u + 2 || p == u + 3) words[1] = {words[1][7:0], b};
    h = u + 8;
    if (p == h) begin
      l2tp_flags = {b, 8'h00};
      pstart = h + 6 + (b[6] ? 2 : 0) + (b[3] ? 4 : 0) + (b[1] ? 2 : 0);
    end
    if (p == h + 1) begin
      c = l2tp_flags[15:8];
      l2tp_flags[7:0] = b;
      if (c[7] && (!c[6] || !c[3] || c[1] || c[0])) rejected = 1;
      if ((c & 8'h34) != 0 || b[7:4] != 0) rejected = 1;
    end
    if (p <= h) return;
    t = h + (l2tp_flags[14] ? 4 : 2);
    if (p == t || p == t + 1) words[2] = {words[2][7:0], b};
    if (p == t + 2 || p == t + 3) words[3] = {words[3][7:0], b};
    q = pstart;
    if (!l2tp_flags[15]) begin
      if ((p == q && b != PPP_ALL_STATIONS) || (p == q + 1 && b != PPP_CTRL)) rejected = 1;
    end
    if (p == q + 2 || p == q + 3) protos[0] = {protos[0][7:0], b};
    if (p == q + 4) ihl = b[3:0] * 4;
    if (p == q + 13) protos[1] = {8'h00, b};
    if (p >= q + 16 && p < q + 20) ips[2] = {ips[2][23:0], b};
    if (p >= q + 20 && p < q + 24) ips[3] = {ips[3][23:0], b};
    in_ports = q + 4 + ihl;
    if (p == in_ports || p == in_ports + 1) words[4] = {words[4][7:0], b};
    if (p == in_ports + 2 || p == in_ports + 3) words[5] = {words[5][7:0], b};
  endfunction

  function automatic int unsigned larger(int unsigned a, int unsigned b);
    return a > b ? a : b;
  endfunction

  function automatic bit classify_byte(frame_in_t fi, output result_t r);
    int unsigned p, count, need, q, inner;
    bit [2:0] cls;
    bit ok, ctl, f1, f2, f3, f4, sip, dip, macok;
    p = pos;
    r = '0;
    parse_byte(p, fi.frame_byte);
    count = p + 1;
    if (pos < 65536) pos++;
    if (!fi.frame_end) return 0;
    q = pstart;
    inner = q + 4 + ihl;
    ctl = l2tp_flags[15];
    need = larger(34, 24 + ohl);
    cls = CLS_CONTROL;
    if (!ctl) begin
      need = larger(need, q + 4);
      if (protos[0] == PPP_IP) begin
        need = larger(need, larger(q + 24, inner + 4));
        if (protos[1][7:0] == IP_PROTO_UDP) cls = CLS_IP_UDP;
        else if (protos[1][7:0] == IP_PROTO_TCP) cls = CLS_IP_TCP;
        else if (protos[1][7:0] == IP_PROTO_ICMP) cls = CLS_IP_ICMP;
        else cls = CLS_IP_OTHER;
      end else if (protos[0] == PPP_LCP) cls = CLS_LCP;
      else if (protos[0] == PPP_CHAP) cls = CLS_CHAP;
      else cls = CLS_PPP_OTHER;
    end
    ok = !rejected && count >= need;
    if (ok && flt_on) begin
      f1 = flt_sip == 0 || flt_sip == ips[0];
      f2 = flt_dip == 0 || flt_dip == ips[1];
      f3 = flt_sport == 0 || flt_sport == words[0];
      f4 = flt_dport == 0 || flt_dport == words[1];
      sip = f1 || flt_sip == ips[2];
      dip = f2 || flt_dip == ips[3];
      macok = (flt_smac == 0 || flt_smac == macs[1]) && (flt_dmac == 0 || flt_dmac == macs[0]);
      case (cls)
        CLS_CONTROL: ok = f1 && f2;
        CLS_IP_UDP: ok = macok && sip && dip && (f3 || flt_sport == words[4])
                         && (f4 || flt_dport == words[5]);
        CLS_IP_TCP: ok = macok && sip && dip && (flt_sport == 0 || flt_sport == words[4])
                         && (flt_dport == 0 || flt_dport == words[5]);
        CLS_IP_ICMP: ok = macok && sip && dip && f3 && f4;
        CLS_LCP, CLS_CHAP: ok = macok && f1 && f2 && f3 && f4;
        default: ok = 0;
      endcase
    end
    if (ok) begin
      verdict_count++;
      r.report = 1;
      r.frame_class = cls;
      if (!ctl) begin
        r.tunnel_id = words[2];
        r.sess_id = words[3];
      end
      r.outer_src_port = words[0];
      r.outer_dst_port = words[1];
      if (cls == CLS_IP_UDP || cls == CLS_IP_TCP) begin
        r.inner_src_port = words[4];
        r.inner_dst_port = words[5];
      end
    end
    r.report_number = verdict_count;
    clear_frame_state();
    return 1;
  endfunction

  always @(posedge clk) begin
    result_t r, want;
    if (rst) begin
      flt_on <= 0; flt_sip <= '0; flt_dip <= '0; flt_smac <= '0; flt_dmac <= '0;
      flt_sport <= '0; flt_dport <= '0;
      verdict_count = '0;
      clear_frame_state();
      verdict_q.delete();
      errors <= 0;
      reports_seen <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FILTER_ENABLE: flt_on <= cfg_data[0];
          REG_WANT_SRC_IP: flt_sip <= cfg_data[31:0];
          REG_WANT_DST_IP: flt_dip <= cfg_data[31:0];
          REG_WANT_SRC_MAC: flt_smac <= cfg_data;
          REG_WANT_DST_MAC: flt_dmac <= cfg_data;
          REG_WANT_SRC_PORT: flt_sport <= cfg_data[15:0];
          REG_WANT_DST_PORT: flt_dport <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (verdict_q.size() == 0) begin
          if (errors < 10) $display("unexpected result beat: %p", result);
          errors <= errors + 1;
        end else begin
          want = verdict_q.pop_front();
          if (result.report !== want.report || result.frame_class !== want.frame_class ||
              result.tunnel_id !== want.tunnel_id || result.sess_id !== want.sess_id ||
              result.outer_src_port !== want.outer_src_port ||
              result.outer_dst_port !== want.outer_dst_port ||
              result.inner_src_port !== want.inner_src_port ||
              result.inner_dst_port !== want.inner_dst_port ||
              result.report_number !== want.report_number) begin
            if (errors < 10) $display("mismatch: expected %p, got %p", want, result);
            errors <= errors + 1;
          end
          if (result.report === 1'b1) reports_seen <= reports_seen + 1;
        end
      end
      if (push && !full) begin
        if (classify_byte(frame, r)) verdict_q.push_back(r);
      end
    end
    pending <= verdict_q.size();
  end

endmodule

// ----- bench/tb_l2tp_tunnel_packet_classifier.sv -----
// ----------------------------------------------------------------------------
// tb_l2tp_tunnel_packet_classifier
// Streams well-formed and damaged L2TP/PPP frames into the classifier under
// several filter settings, with random idling on both sides and one long
// result stall, while the checker predicts and compares every verdict.
// ----------------------------------------------------------------------------
module tb_l2tp_tunnel_packet_classifier;
  import l2tp_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic                   clk = 0;
  logic                   rst = 1;
  logic                   push = 0;
  logic                   full;
  frame_in_t              frame = '0;
  logic                   empty;
  logic                   pop = 0;
  result_t                result;
  logic                   cfg_write = 0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     errors, pending, reports_seen;

  bit        quiet = 0;
  bit        hold_req = 0;
  bit        hold_done = 0;
  int        frames_sent = 0;
  int        bytes_sent = 0;
  bit [31:0] sel_sip, sel_dip;
  bit [47:0] sel_smac, sel_dmac;
  bit [15:0] sel_sport, sel_dport;

  l2tp_tunnel_packet_classifier dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .frame(frame),
    .empty(empty), .pop(pop), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  l2tp_checker u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .frame(frame),
    .empty(empty), .pop(pop), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .reports_seen(reports_seen)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // The result side idles in bursts, and once stalls long enough to back up the input.
  initial begin
    @(negedge rst);
    forever begin
      if (hold_req && !hold_done) begin
        pop <= 0;
        repeat (800) @(posedge clk);
        hold_done = 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        pop <= 0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        pop <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic send_beat(bit [7:0] b, bit last);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    push <= 1;
    frame <= '{frame_byte: b, frame_end: last};
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  function automatic bit [47:0] pick48(bit [47:0] sel);
    return $urandom_range(0, 1) ? sel : 48'({$urandom(), $urandom()});
  endfunction

  function automatic bit [31:0] pick32(bit [31:0] sel);
    return $urandom_range(0, 1) ? sel : $urandom();
  endfunction

  function automatic bit [15:0] pick16(bit [15:0] sel);
    return $urandom_range(0, 1) ? sel : 16'($urandom());
  endfunction

  // kind is a frame class, or -1 for a random one; damaged frames break one rule at random.
  task automatic send_frame(int kind, bit damaged);
    bit [7:0] fb[256];
    int ihl, iihl, u, h, t, q, in_ports, need, len, k;
    bit [7:0] flags;
    bit [15:0] proto;
    for (int i = 0; i < 256; i++) fb[i] = 8'($urandom());
    if (kind < 0) kind = $urandom_range(0, 7);
    k = damaged ? $urandom_range(0, 7) : 8;
    {fb[0], fb[1], fb[2], fb[3], fb[4], fb[5]} = pick48(sel_dmac);
    {fb[6], fb[7], fb[8], fb[9], fb[10], fb[11]} = pick48(sel_smac);
    fb[12] = ETH_IPV4_HI;
    fb[13] = ETH_IPV4_LO;
    if (k == 0) fb[12 + $urandom_range(0, 1)] = 8'($urandom());
    ihl = (k == 1) ? $urandom_range(0, 15) : $urandom_range(5, 6);
    {fb[26], fb[27], fb[28], fb[29]} = pick32(sel_sip);
    {fb[30], fb[31], fb[32], fb[33]} = pick32(sel_dip);
    fb[14] = {4'h4, ihl[3:0]};
    fb[23] = (k == 2) ? 8'($urandom()) : IP_PROTO_UDP;
    u = 14 + ihl * 4;
    {fb[u], fb[u + 1]} = pick16(sel_sport);
    {fb[u + 2], fb[u + 3]} = pick16(sel_dport);
    h = u + 8;
    if (kind == CLS_CONTROL) flags = 8'hC8 | ($urandom_range(0, 2) == 0 ? 8'h02 : 8'h00);
    else flags = 8'($urandom()) & 8'h4A;
    if (k == 3) flags = 8'($urandom());
    fb[h] = flags;
    fb[h + 1] = (k == 4) ? 8'($urandom()) : 8'h02;
    t = h + (flags[6] ? 4 : 2);
    {fb[t], fb[t + 1], fb[t + 2], fb[t + 3]} = $urandom();
    q = h + 6 + (flags[6] ? 2 : 0) + (flags[3] ? 4 : 0) + (flags[1] ? 2 : 0);
    need = (h + 2 > 34) ? h + 2 : 34;
    if (!flags[7]) begin
      fb[q] = PPP_ALL_STATIONS;
      fb[q + 1] = PPP_CTRL;
      if (k == 5) fb[q + $urandom_range(0, 1)] = 8'($urandom());
      case (kind)
        CLS_LCP: proto = PPP_LCP;
        CLS_CHAP: proto = PPP_CHAP;
        CLS_PPP_OTHER: proto = 16'($urandom());
        default: proto = PPP_IP;
      endcase
      {fb[q + 2], fb[q + 3]} = proto;
      if (q + 4 > need) need = q + 4;
      if (proto == PPP_IP) begin
        iihl = (k == 6) ? $urandom_range(0, 15) : 5;
        fb[q + 4] = {4'h4, iihl[3:0]};
        case (kind)
          CLS_IP_UDP: fb[q + 13] = IP_PROTO_UDP;
          CLS_IP_TCP: fb[q + 13] = IP_PROTO_TCP;
          CLS_IP_ICMP: fb[q + 13] = IP_PROTO_ICMP;
          default: ;
        endcase
        {fb[q + 16], fb[q + 17], fb[q + 18], fb[q + 19]} = pick32(sel_sip);
        {fb[q + 20], fb[q + 21], fb[q + 22], fb[q + 23]} = pick32(sel_dip);
        in_ports = q + 4 + iihl * 4;
        {fb[in_ports], fb[in_ports + 1]} = pick16(sel_sport);
        {fb[in_ports + 2], fb[in_ports + 3]} = pick16(sel_dport);
        if (q + 24 > need) need = q + 24;
        if (in_ports + 4 > need) need = in_ports + 4;
      end
    end
    len = need + $urandom_range(0, 6);
    if (k == 7) len = $urandom_range(1, need - 1);
    if (len > 256) len = 256;
    for (int i = 0; i < len; i++) send_beat(fb[i], i == len - 1);
    frames_sent++;
  endtask

  task automatic set_filters(bit on, bit [31:0] sip, bit [31:0] dip, bit [47:0] smac,
                             bit [47:0] dmac, bit [15:0] sport, bit [15:0] dport);
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    sel_sip = sip; sel_dip = dip; sel_smac = smac; sel_dmac = dmac;
    sel_sport = sport; sel_dport = dport;
    for (int i = 0; i < 7; i++) begin
      cfg_write <= 1;
      cfg_index <= i[CFG_INDEX_W-1:0];
      case (i)
        REG_FILTER_ENABLE: cfg_data <= {47'd0, on};
        REG_WANT_SRC_IP: cfg_data <= {16'd0, sip};
        REG_WANT_DST_IP: cfg_data <= {16'd0, dip};
        REG_WANT_SRC_MAC: cfg_data <= smac;
        REG_WANT_DST_MAC: cfg_data <= dmac;
        REG_WANT_SRC_PORT: cfg_data <= {32'd0, sport};
        default: cfg_data <= {32'd0, dport};
      endcase
      @(posedge clk);
    end
    cfg_write <= 0;
  endtask

  function automatic bit [31:0] maybe_zero(bit [31:0] v);
    return $urandom_range(0, 3) == 0 ? 32'd0 : v;
  endfunction

  initial begin
    int phase;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    sel_sip = $urandom(); sel_dip = $urandom(); sel_smac = 48'({$urandom(), $urandom()});
    sel_dmac = 48'({$urandom(), $urandom()}); sel_sport = 16'($urandom());
    sel_dport = 16'($urandom());
    for (int c = CLS_CONTROL; c <= CLS_PPP_OTHER; c++) send_frame(c, 0);
    send_beat(8'($urandom()), 1);
    frames_sent++;
    for (int d = 0; d < 8; d++) send_frame(-1, 1);

    // Short frames pile up results while the result side is held off.
    hold_req = 1;
    for (int i = 0; i < 24; i++) send_beat(8'($urandom()), 1);
    frames_sent += 24;
    while (!hold_done) send_frame(-1, 0);

    phase = 0;
    while (bytes_sent < 1450) begin
      if (phase % 2 == 1) set_filters(0, $urandom(), $urandom(), '0, '0, '0, '0);
      else set_filters(1, maybe_zero($urandom()), maybe_zero($urandom()),
                       48'({maybe_zero($urandom()), $urandom()}),
                       48'({maybe_zero($urandom()), $urandom()}),
                       16'(maybe_zero($urandom())), 16'(maybe_zero($urandom())));
      for (int i = 0; i < 4; i++) send_frame(-1, $urandom_range(0, 4) == 0);
      phase++;
    end
    quiet = 1;
    for (int i = 0; i < 2; i++) send_frame(-1, $urandom_range(0, 4) == 0);
    push <= 0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d frames in %0d bytes over %0d filter settings.",
             frames_sent, bytes_sent, phase + 1);
    $display("The block reported %0d frames; %0d mismatches were counted.",
             reports_seen, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
